>>> hw/rtl/lsse_pkg.sv
// ----------------------------------------------------------------------------
// lsse_pkg
// Shared constants, types and helpers of the lidar scan sector extractor.
// ----------------------------------------------------------------------------
package lsse_pkg;

  localparam int unsigned SCAN_DEPTH = 2048;
  localparam int unsigned AVG_WINDOW = 5;

  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned DIR_W      = 11;
  localparam int unsigned NUM_DIRS   = 5;
  localparam int unsigned DIR_SEL_W  = $clog2(NUM_DIRS);
  localparam int unsigned IDX_W      = $clog2(SCAN_DEPTH);
  localparam int unsigned COUNT_W    = $clog2(SCAN_DEPTH + 1);
  localparam int unsigned HALF_WIN   = AVG_WINDOW / 2;
  localparam int unsigned WIN_LEN    = 2 * HALF_WIN + 1;
  localparam int unsigned CNT_W      = $clog2(WIN_LEN + 1);
  localparam int unsigned SUM_W      = RANGE_W + $clog2(WIN_LEN);
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);
  localparam int unsigned NUM_BUFS   = 2;
  localparam int unsigned JOB_DEPTH  = 2;
  localparam int unsigned JOB_PTR_W  = $clog2(JOB_DEPTH);
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [RANGE_W-1:0] NO_RETURN = '1;

  localparam logic [RANGE_W-1:0] RST_RANGE_FLOOR    = 16'd120;
  localparam logic [RANGE_W-1:0] RST_RANGE_CEILING  = 16'd3500;
  localparam logic [RANGE_W-1:0] RST_WALL_THRESHOLD = 16'd500;
  localparam logic [NUM_DIRS-1:0][DIR_W-1:0] RST_DIR_INDEX =
    {11'd225, 11'd135, 11'd270, 11'd90, 11'd180};

  typedef enum logic [DIR_SEL_W-1:0] {
    DIR_FRONT,
    DIR_RIGHT,
    DIR_LEFT,
    DIR_RDIAG,
    DIR_LDIAG
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_FLOOR,
    REG_RANGE_CEILING,
    REG_WALL_THRESHOLD,
    REG_FRONT_INDEX,
    REG_RIGHT_INDEX,
    REG_LEFT_INDEX,
    REG_RIGHT_DIAG_INDEX,
    REG_LEFT_DIAG_INDEX
  } cfg_reg_e;

  typedef struct packed {
    logic [RANGE_W-1:0]                range_floor;
    logic [RANGE_W-1:0]                range_ceiling;
    logic [RANGE_W-1:0]                wall_threshold;
    logic [NUM_DIRS-1:0][DIR_W-1:0]    dir_index;
  } cfg_t;

  typedef struct packed {
    logic               empty;
    logic               buf_sel;
    logic [COUNT_W-1:0] n;
    logic [RANGE_W-1:0] min_range;
  } job_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W:0]     addr;
    logic [RANGE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic buf_sel;
  } rel_t;

  function automatic logic range_ok(input logic [RANGE_W-1:0] r,
                                    input logic [RANGE_W-1:0] lo,
                                    input logic [RANGE_W-1:0] hi);
    return (r != NO_RETURN) && (r >= lo) && (r <= hi);
  endfunction

endpackage

>>> hw/rtl/lsse_if.sv
// ----------------------------------------------------------------------------
// lsse_if
// Valid/ready channels for range samples and scan results.
// ----------------------------------------------------------------------------
interface lsse_sample_if;
  logic                         valid;
  logic                         ready;
  logic [lsse_pkg::RANGE_W-1:0] sample_range;
  logic                         last_sample;
  logic                         empty_scan;

  modport source (output valid, sample_range, last_sample, empty_scan, input ready);
  modport sink   (input valid, sample_range, last_sample, empty_scan, output ready);
endinterface

interface lsse_result_if;
  logic                         valid;
  logic                         ready;
  logic [lsse_pkg::RANGE_W-1:0] front_dist;
  logic [lsse_pkg::RANGE_W-1:0] right_dist;
  logic [lsse_pkg::RANGE_W-1:0] left_dist;
  logic [lsse_pkg::RANGE_W-1:0] right_diag_dist;
  logic [lsse_pkg::RANGE_W-1:0] left_diag_dist;
  logic [lsse_pkg::RANGE_W-1:0] nearest_range;
  logic                         scan_valid;
  logic                         right_wall;
  logic                         right_gap;

  modport source (output valid, front_dist, right_dist, left_dist, right_diag_dist,
                  left_diag_dist, nearest_range, scan_valid, right_wall, right_gap,
                  input ready);
  modport sink   (input valid, front_dist, right_dist, left_dist, right_diag_dist,
                  left_diag_dist, nearest_range, scan_valid, right_wall, right_gap,
                  output ready);
endinterface

>>> hw/rtl/lsse_front.sv
// ----------------------------------------------------------------------------
// lsse_front
// Sample intake: store writes, running minimum and scan-end job issue.
// ----------------------------------------------------------------------------
module lsse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsse_pkg::cfg_t      cfg_i,
  lsse_sample_if.sink         smp,
  input  lsse_pkg::rel_t      rel_i,
  input  logic                job_full_i,
  output logic                job_push_o,
  output lsse_pkg::job_t      job_o,
  output lsse_pkg::store_wr_t st_wr_o
);

  logic [lsse_pkg::NUM_BUFS-1:0] busy_q, busy_d;
  logic                          wr_sel_q;
  logic [lsse_pkg::COUNT_W-1:0]  count_q, count_inc;
  logic [lsse_pkg::RANGE_W-1:0]  min_q, min_upd;
  logic                          accept;
  logic                          has_room;
  logic                          scan_end;

  assign smp.ready = !job_full_i && !busy_q[wr_sel_q];
  assign accept    = smp.valid && smp.ready;
  assign has_room  = count_q != lsse_pkg::COUNT_W'(lsse_pkg::SCAN_DEPTH);
  assign count_inc = has_room ? count_q + 1'b1 : count_q;
  assign min_upd   = (lsse_pkg::range_ok(smp.sample_range, cfg_i.range_floor,
                                         cfg_i.range_ceiling)
                      && (smp.sample_range < min_q)) ? smp.sample_range : min_q;
  assign scan_end  = accept && !smp.empty_scan && smp.last_sample;

  assign st_wr_o.we   = accept && !smp.empty_scan && has_room;
  assign st_wr_o.addr = {wr_sel_q, count_q[lsse_pkg::IDX_W-1:0]};
  assign st_wr_o.data = smp.sample_range;

  assign job_push_o      = accept && (smp.empty_scan || smp.last_sample);
  assign job_o.empty     = smp.empty_scan;
  assign job_o.buf_sel   = wr_sel_q;
  assign job_o.n         = count_inc;
  assign job_o.min_range = min_upd;

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.buf_sel] = 1'b0;
    end
    if (scan_end) begin
      busy_d[wr_sel_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      wr_sel_q <= 1'b0;
      count_q  <= '0;
      min_q    <= lsse_pkg::NO_RETURN;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        if (smp.empty_scan || smp.last_sample) begin
          count_q <= '0;
          min_q   <= lsse_pkg::NO_RETURN;
        end else begin
          count_q <= count_inc;
          min_q   <= min_upd;
        end
        if (scan_end) begin
          wr_sel_q <= !wr_sel_q;
        end
      end
    end
  end

endmodule

>>> hw/rtl/lsse_fifo.sv
// ----------------------------------------------------------------------------
// lsse_fifo
// Short job queue between intake and the window engine.
// ----------------------------------------------------------------------------
module lsse_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsse_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lsse_pkg::job_t head_o
);

  lsse_pkg::job_t                 slot_q [lsse_pkg::JOB_DEPTH];
  logic [lsse_pkg::JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [lsse_pkg::JOB_PTR_W:0]   fill_q;

  assign full_o  = fill_q == (lsse_pkg::JOB_PTR_W + 1)'(lsse_pkg::JOB_DEPTH);
  assign empty_o = fill_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/lsse_back.sv
// ----------------------------------------------------------------------------
// lsse_back
// Window engine: double-buffered scan store, windowed means, wall history
// and the result register.
// ----------------------------------------------------------------------------
module lsse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsse_pkg::cfg_t      cfg_i,
  input  lsse_pkg::store_wr_t st_wr_i,
  input  logic                job_empty_i,
  input  lsse_pkg::job_t      job_i,
  output logic                job_pop_o,
  output lsse_pkg::rel_t      rel_o,
  lsse_result_if.source       res
);

  localparam int unsigned STORE_DEPTH = lsse_pkg::NUM_BUFS * (1 << lsse_pkg::IDX_W);
  localparam int unsigned CMP_W =
    (lsse_pkg::COUNT_W > lsse_pkg::DIR_W) ? lsse_pkg::COUNT_W : lsse_pkg::DIR_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_BACK,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_NEXT,
    ST_WALL,
    ST_EMIT
  } state_e;

  logic [lsse_pkg::RANGE_W-1:0] store_mem [STORE_DEPTH];
  logic [lsse_pkg::RANGE_W-1:0] rd_data_q;
  logic                         rd_en;
  logic [lsse_pkg::IDX_W:0]     rd_addr;

  state_e                                               state_q;
  lsse_pkg::job_t                                       job_q;
  logic [lsse_pkg::DIR_SEL_W-1:0]                       dir_q;
  logic [lsse_pkg::IDX_W-1:0]                           idx_q;
  logic [lsse_pkg::CNT_W-1:0]                           step_q;
  logic                                                 rd_v_q;
  logic [lsse_pkg::SUM_W-1:0]                           sum_q;
  logic [lsse_pkg::CNT_W-1:0]                           cnt_q;
  logic [lsse_pkg::CNT_W-1:0]                           rem_q;
  logic [lsse_pkg::DIV_CNT_W-1:0]                       div_cnt_q;
  logic [lsse_pkg::NUM_DIRS-1:0][lsse_pkg::RANGE_W-1:0] dist_q;
  logic [lsse_pkg::RANGE_W-1:0]                         held_min_q;
  logic                                                 valid_flag_q;
  logic                                                 wall_now_q;
  logic                                                 gap_q;
  lsse_pkg::rel_t                                       rel_q;
  logic                                                 out_valid_q;
  logic [lsse_pkg::NUM_DIRS-1:0][lsse_pkg::RANGE_W-1:0] out_dist_q;
  logic [lsse_pkg::RANGE_W-1:0]                         out_min_q;
  logic                                                 out_scan_valid_q;
  logic                                                 out_wall_q;
  logic                                                 out_gap_q;

  logic [lsse_pkg::COUNT_W-1:0] n_last;
  logic [lsse_pkg::IDX_W-1:0]   idx_last;
  logic [CMP_W-1:0]             dir_cmp;
  logic [CMP_W-1:0]             n_cmp;
  logic [lsse_pkg::IDX_W-1:0]   centre;
  logic [lsse_pkg::IDX_W-1:0]   idx_dec;
  logic [lsse_pkg::IDX_W-1:0]   idx_inc;
  logic                         rd_ok;
  logic [lsse_pkg::CNT_W:0]     rem_shift;
  logic [lsse_pkg::CNT_W:0]     rem_sub;
  logic                         fits;
  logic                         right_near;

  assign n_last   = job_q.n - 1'b1;
  assign idx_last = n_last[lsse_pkg::IDX_W-1:0];
  assign dir_cmp  = CMP_W'(cfg_i.dir_index[dir_q]);
  assign n_cmp    = CMP_W'(job_q.n);
  assign centre   = (dir_cmp < n_cmp) ? dir_cmp[lsse_pkg::IDX_W-1:0] : idx_last;
  assign idx_dec  = (idx_q == '0) ? idx_last : idx_q - 1'b1;
  assign idx_inc  = (lsse_pkg::COUNT_W'(idx_q) == n_last) ? '0 : idx_q + 1'b1;

  assign rd_ok     = lsse_pkg::range_ok(rd_data_q, cfg_i.range_floor, cfg_i.range_ceiling);
  assign rem_shift = {rem_q, sum_q[lsse_pkg::SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, cnt_q};
  assign fits      = rem_shift >= {1'b0, cnt_q};

  assign right_near = dist_q[lsse_pkg::DIR_RIGHT] < cfg_i.wall_threshold;

  assign rd_en     = state_q == ST_READ;
  assign rd_addr   = {job_q.buf_sel, idx_q};
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i;
  assign rel_o     = rel_q;

  assign res.valid           = out_valid_q;
  assign res.front_dist      = out_dist_q[lsse_pkg::DIR_FRONT];
  assign res.right_dist      = out_dist_q[lsse_pkg::DIR_RIGHT];
  assign res.left_dist       = out_dist_q[lsse_pkg::DIR_LEFT];
  assign res.right_diag_dist = out_dist_q[lsse_pkg::DIR_RDIAG];
  assign res.left_diag_dist  = out_dist_q[lsse_pkg::DIR_LDIAG];
  assign res.nearest_range   = out_min_q;
  assign res.scan_valid      = out_scan_valid_q;
  assign res.right_wall      = out_wall_q;
  assign res.right_gap       = out_gap_q;

  always_ff @(posedge clk_i) begin
    if (st_wr_i.we) begin
      store_mem[st_wr_i.addr] <= st_wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      job_q            <= '0;
      dir_q            <= '0;
      idx_q            <= '0;
      step_q           <= '0;
      rd_v_q           <= 1'b0;
      sum_q            <= '0;
      cnt_q            <= '0;
      rem_q            <= '0;
      div_cnt_q        <= '0;
      dist_q           <= {lsse_pkg::NUM_DIRS{lsse_pkg::NO_RETURN}};
      held_min_q       <= lsse_pkg::NO_RETURN;
      valid_flag_q     <= 1'b0;
      wall_now_q       <= 1'b0;
      gap_q            <= 1'b0;
      rel_q            <= '0;
      out_valid_q      <= 1'b0;
      out_dist_q       <= '0;
      out_min_q        <= '0;
      out_scan_valid_q <= 1'b0;
      out_wall_q       <= 1'b0;
      out_gap_q        <= 1'b0;
    end else begin
      rel_q.valid <= 1'b0;
      rd_v_q      <= state_q == ST_READ;
      if (rd_v_q && rd_ok) begin
        sum_q <= sum_q + lsse_pkg::SUM_W'(rd_data_q);
        cnt_q <= cnt_q + 1'b1;
      end
      if (res.valid && res.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            job_q <= job_i;
            if (job_i.empty) begin
              valid_flag_q <= 1'b0;
              gap_q        <= 1'b0;
              state_q      <= ST_EMIT;
            end else begin
              dir_q   <= '0;
              state_q <= ST_CENTRE;
            end
          end
        end
        ST_CENTRE: begin
          idx_q   <= centre;
          step_q  <= '0;
          sum_q   <= '0;
          cnt_q   <= '0;
          state_q <= (lsse_pkg::HALF_WIN == 0) ? ST_READ : ST_BACK;
        end
        ST_BACK: begin
          idx_q <= idx_dec;
          if (step_q == lsse_pkg::CNT_W'(lsse_pkg::HALF_WIN - 1)) begin
            step_q  <= '0;
            state_q <= ST_READ;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_READ: begin
          idx_q <= idx_inc;
          if (step_q == lsse_pkg::CNT_W'(lsse_pkg::WIN_LEN - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          div_cnt_q <= '0;
          rem_q     <= '0;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_NEXT;
          end else begin
            rem_q     <= fits ? rem_sub[lsse_pkg::CNT_W-1:0] : rem_shift[lsse_pkg::CNT_W-1:0];
            sum_q     <= {sum_q[lsse_pkg::SUM_W-2:0], fits};
            div_cnt_q <= div_cnt_q + 1'b1;
            if (div_cnt_q == lsse_pkg::DIV_CNT_W'(lsse_pkg::SUM_W - 1)) begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_NEXT: begin
          dist_q[dir_q] <= (cnt_q == '0) ? lsse_pkg::NO_RETURN
                                         : sum_q[lsse_pkg::RANGE_W-1:0];
          if (dir_q == lsse_pkg::DIR_SEL_W'(lsse_pkg::NUM_DIRS - 1)) begin
            rel_q.valid   <= 1'b1;
            rel_q.buf_sel <= job_q.buf_sel;
            state_q       <= ST_WALL;
          end else begin
            dir_q   <= dir_q + 1'b1;
            state_q <= ST_CENTRE;
          end
        end
        ST_WALL: begin
          wall_now_q   <= right_near;
          gap_q        <= wall_now_q && !right_near;
          held_min_q   <= job_q.min_range;
          valid_flag_q <= 1'b1;
          state_q      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || res.ready) begin
            out_valid_q      <= 1'b1;
            out_dist_q       <= dist_q;
            out_min_q        <= held_min_q;
            out_scan_valid_q <= valid_flag_q;
            out_wall_q       <= valid_flag_q && wall_now_q;
            out_gap_q        <= valid_flag_q && gap_q;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/lidar_scan_sector_extractor_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_sector_extractor_core
// Collects lidar scans and reports nearest range, five windowed direction
// distances and right-wall / gap flags once per scan.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     transfer
//  sample_ch  in   valid/ready   one range sample, last/empty markers
//  result_ch  out  valid/ready   one result per finished or empty scan
//  cfg_*      in   write enable  one register write, no read-back
//
//  Samples transfer one per cycle into one half of a two-half scan store.
//  A finished scan keeps the window engine busy with serial store reads
//  and the bit-serial divider for each of the five directions; an empty
//  scan goes straight to the result register.
//  Intake stalls only when the store half it needs is still being read
//  or the job queue is full. No clearing pass after reset.
// ----------------------------------------------------------------------------
module lidar_scan_sector_extractor_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lsse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsse_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lsse_sample_if.sink                       sample_ch,
  lsse_result_if.source                     result_ch
);

  lsse_pkg::cfg_t      cfg_q;
  lsse_pkg::job_t      job_in;
  lsse_pkg::job_t      job_head;
  lsse_pkg::store_wr_t st_wr;
  lsse_pkg::rel_t      rel;
  logic                job_push;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_floor    <= lsse_pkg::RST_RANGE_FLOOR;
      cfg_q.range_ceiling  <= lsse_pkg::RST_RANGE_CEILING;
      cfg_q.wall_threshold <= lsse_pkg::RST_WALL_THRESHOLD;
      cfg_q.dir_index      <= lsse_pkg::RST_DIR_INDEX;
    end else if (cfg_we_i) begin
      unique case (lsse_pkg::cfg_reg_e'(cfg_idx_i))
        lsse_pkg::REG_RANGE_FLOOR:      cfg_q.range_floor    <= cfg_data_i;
        lsse_pkg::REG_RANGE_CEILING:    cfg_q.range_ceiling  <= cfg_data_i;
        lsse_pkg::REG_WALL_THRESHOLD:   cfg_q.wall_threshold <= cfg_data_i;
        lsse_pkg::REG_FRONT_INDEX:
          cfg_q.dir_index[lsse_pkg::DIR_FRONT] <= cfg_data_i[lsse_pkg::DIR_W-1:0];
        lsse_pkg::REG_RIGHT_INDEX:
          cfg_q.dir_index[lsse_pkg::DIR_RIGHT] <= cfg_data_i[lsse_pkg::DIR_W-1:0];
        lsse_pkg::REG_LEFT_INDEX:
          cfg_q.dir_index[lsse_pkg::DIR_LEFT]  <= cfg_data_i[lsse_pkg::DIR_W-1:0];
        lsse_pkg::REG_RIGHT_DIAG_INDEX:
          cfg_q.dir_index[lsse_pkg::DIR_RDIAG] <= cfg_data_i[lsse_pkg::DIR_W-1:0];
        lsse_pkg::REG_LEFT_DIAG_INDEX:
          cfg_q.dir_index[lsse_pkg::DIR_LDIAG] <= cfg_data_i[lsse_pkg::DIR_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  lsse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .smp        (sample_ch),
    .rel_i      (rel),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .st_wr_o    (st_wr)
  );

  lsse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .head_o  (job_head)
  );

  lsse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .st_wr_i     (st_wr),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .rel_o       (rel),
    .res         (result_ch)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("job queue underflow");

  a_no_write_to_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel.valid |-> !(st_wr.we && (st_wr.addr[lsse_pkg::IDX_W] == rel.buf_sel)))
    else $error("store half written while still owned by the window engine");
`endif

endmodule

>>> test/lidar_scan_sector_extractor_core_test.sv
// ----------------------------------------------------------------------------
// lidar_scan_sector_extractor_core_test
// Streams lidar scans into the sector extractor under random sender bursts
// and receiver stalls, predicts every scan result from its own model of the
// scan store, windowed means and wall history, and compares each result
// field by field. Covers short wrapping scans, clamped direction indices,
// empty and aborted scans and register extremes.
// ----------------------------------------------------------------------------
module lidar_scan_sector_extractor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsse_pkg::*;

  localparam int unsigned ENGINE_SLACK  = 200;
  localparam int unsigned RANDOM_PHASES = 6;

  typedef struct packed {
    logic [RANGE_W-1:0] sample_range;
    logic               last_sample;
    logic               empty_scan;
  } scan_sample_t;

  typedef struct packed {
    logic [NUM_DIRS-1:0][RANGE_W-1:0] dir_dist;
    logic [RANGE_W-1:0]               nearest_range;
    logic                             scan_valid;
    logic                             right_wall;
    logic                             right_gap;
  } scan_result_t;

  class sector_tracker;
    logic [RANGE_W-1:0] floor_mm;
    logic [RANGE_W-1:0] ceiling_mm;
    logic [RANGE_W-1:0] wall_mm;
    logic [DIR_W-1:0]   dir_idx [NUM_DIRS];
    logic [RANGE_W-1:0] store [SCAN_DEPTH];
    int unsigned        count;
    logic [RANGE_W-1:0] run_min;
    logic [RANGE_W-1:0] held_min;
    logic [RANGE_W-1:0] held_dist [NUM_DIRS];
    bit                 valid_flag;
    bit                 wall_now;
    bit                 wall_prev;
    scan_result_t       due_results [$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      floor_mm   = RST_RANGE_FLOOR;
      ceiling_mm = RST_RANGE_CEILING;
      wall_mm    = RST_WALL_THRESHOLD;
      for (int d = 0; d < NUM_DIRS; d++) begin
        dir_idx[d]   = RST_DIR_INDEX[d];
        held_dist[d] = NO_RETURN;
      end
      count      = 0;
      run_min    = NO_RETURN;
      held_min   = NO_RETURN;
      valid_flag = 1'b0;
      wall_now   = 1'b0;
      wall_prev  = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_RANGE_FLOOR:    floor_mm = v;
        REG_RANGE_CEILING:  ceiling_mm = v;
        REG_WALL_THRESHOLD: wall_mm = v;
        default:            dir_idx[r - REG_FRONT_INDEX] = v[DIR_W-1:0];
      endcase
    endfunction

    function bit in_band(logic [RANGE_W-1:0] r);
      return r != NO_RETURN && r >= floor_mm && r <= ceiling_mm;
    endfunction

    function logic [RANGE_W-1:0] window_mean(int unsigned centre, int unsigned n);
      int unsigned half;
      int unsigned sum;
      int unsigned hits;
      int unsigned idx;
      half = AVG_WINDOW / 2;
      sum  = 0;
      hits = 0;
      for (int unsigned k = 0; k <= 2 * half; k++) begin
        idx = (centre + k + n * (half / n + 1) - half) % n;
        if (in_band(store[idx])) begin
          sum += store[idx];
          hits++;
        end
      end
      return (hits != 0) ? RANGE_W'(sum / hits) : NO_RETURN;
    endfunction

    function void take_sample(scan_sample_t s);
      scan_result_t want;
      bit           gap;
      int unsigned  centre;
      gap = 1'b0;
      if (s.empty_scan) begin
        valid_flag = 1'b0;
        count      = 0;
        run_min    = NO_RETURN;
      end else begin
        if (count < SCAN_DEPTH) begin
          store[count] = s.sample_range;
          count++;
        end
        if (in_band(s.sample_range) && s.sample_range < run_min) run_min = s.sample_range;
        if (!s.last_sample) return;
        for (int d = 0; d < NUM_DIRS; d++) begin
          centre       = (dir_idx[d] < count) ? dir_idx[d] : count - 1;
          held_dist[d] = window_mean(centre, count);
        end
        held_min   = run_min;
        valid_flag = 1'b1;
        wall_prev  = wall_now;
        wall_now   = held_dist[DIR_RIGHT] < wall_mm;
        gap        = wall_prev && !wall_now;
        count      = 0;
        run_min    = NO_RETURN;
      end
      for (int d = 0; d < NUM_DIRS; d++) want.dir_dist[d] = held_dist[d];
      want.nearest_range = held_min;
      want.scan_valid    = valid_flag;
      want.right_wall    = valid_flag && wall_now;
      want.right_gap     = valid_flag && gap;
      due_results.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] result %0d: %s", $time, checked, msg);
    endtask

    task compare_field(string name, logic [RANGE_W-1:0] got, logic [RANGE_W-1:0] want);
      if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(scan_result_t got);
      scan_result_t want;
      dir_e         dir;
      checked++;
      if (due_results.size() == 0) begin
        report("unexpected result transfer");
        return;
      end
      want = due_results.pop_front();
      for (int d = 0; d < NUM_DIRS; d++) begin
        dir = dir_e'(d);
        compare_field(dir.name(), got.dir_dist[d], want.dir_dist[d]);
      end
      compare_field("nearest_range", got.nearest_range, want.nearest_range);
      compare_field("scan_valid", got.scan_valid, want.scan_valid);
      compare_field("right_wall", got.right_wall, want.right_wall);
      compare_field("right_gap", got.right_gap, want.right_gap);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lsse_sample_if sample_ch ();
  lsse_result_if result_ch ();

  lidar_scan_sector_extractor_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_ch  (sample_ch),
    .result_ch  (result_ch)
  );

  sector_tracker tracker = new();

  logic [CFG_DATA_W-1:0] reg_plan [1 << CFG_IDX_W];
  bit          pacing;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned items_sent;
  int          hold_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_sample(logic [RANGE_W-1:0] r, bit last, bit empty);
    scan_sample_t s;
    if (pacing && burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s.sample_range = r;
    s.last_sample  = last;
    s.empty_scan   = empty;
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_range <= r;
    sample_ch.last_sample  <= last;
    sample_ch.empty_scan   <= empty;
    do @(posedge clk_i); while (!sample_ch.ready);
    tracker.take_sample(s);
    items_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 11))
      0:       return NO_RETURN;
      1:       return '0;
      2:       return tracker.floor_mm - 1'b1;
      3:       return tracker.floor_mm;
      4:       return tracker.ceiling_mm;
      5:       return tracker.ceiling_mm + 1'b1;
      6, 7:    return RANGE_W'($urandom);
      default: return RANGE_W'($urandom_range(tracker.ceiling_mm, tracker.floor_mm));
    endcase
  endfunction

  function automatic int unsigned pick_len(bit short_only);
    if (short_only) return $urandom_range(1, 3);
    case ($urandom_range(0, 19))
      0:             return $urandom_range(41, 120);
      1, 2, 3, 4, 5: return $urandom_range(13, 40);
      default:       return $urandom_range(1, 12);
    endcase
  endfunction

  // abort some scans with an empty marker part way through
  task automatic send_scan(int unsigned len, bit allow_abort);
    int unsigned cut;
    cut = (allow_abort && $urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == cut) begin
        send_sample(RANGE_W'($urandom), 1'($urandom), 1'b1);
        return;
      end
      send_sample(pick_range(), i == len - 1, 1'b0);
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (ENGINE_SLACK) @(posedge clk_i);
  endtask

  task automatic configure();
    cfg_reg_e r;
    drain();
    r = r.first();
    do begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= reg_plan[r];
      @(posedge clk_i);
      tracker.write_reg(r, reg_plan[r]);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
    burst_left = 0;
  endtask

  scan_sample_t directed [] = '{
    '{16'h1234, 1'b0, 1'b1},
    '{16'hFFFF, 1'b1, 1'b0},
    '{16'd0,    1'b0, 1'b0},
    '{16'd119,  1'b0, 1'b0},
    '{16'd120,  1'b0, 1'b0},
    '{16'd3500, 1'b0, 1'b0},
    '{16'd3501, 1'b0, 1'b0},
    '{16'hFFFF, 1'b1, 1'b0},
    '{16'd130,  1'b0, 1'b0},
    '{16'd3499, 1'b1, 1'b0},
    '{16'd400,  1'b0, 1'b0},
    '{16'd300,  1'b0, 1'b0},
    '{16'd200,  1'b1, 1'b0},
    '{16'hA5A5, 1'b1, 1'b1},
    '{16'd1000, 1'b0, 1'b0},
    '{16'd1000, 1'b0, 1'b0},
    '{16'd1000, 1'b1, 1'b0},
    '{16'd450,  1'b1, 1'b0},
    '{16'hFFFE, 1'b1, 1'b0}
  };

  initial begin
    scan_result_t got;
    int unsigned  mode;
    int unsigned  mode_left;
    result_ch.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) begin
        got.dir_dist[DIR_FRONT] = result_ch.front_dist;
        got.dir_dist[DIR_RIGHT] = result_ch.right_dist;
        got.dir_dist[DIR_LEFT]  = result_ch.left_dist;
        got.dir_dist[DIR_RDIAG] = result_ch.right_diag_dist;
        got.dir_dist[DIR_LDIAG] = result_ch.left_diag_dist;
        got.nearest_range       = result_ch.nearest_range;
        got.scan_valid          = result_ch.scan_valid;
        got.right_wall          = result_ch.right_wall;
        got.right_gap           = result_ch.right_gap;
        tracker.check_result(got);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom);
          2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= mode_left[0];
        endcase
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    bit          short_only;
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= REG_RANGE_FLOOR;
    cfg_data_i             <= '0;
    sample_ch.valid        <= 1'b0;
    sample_ch.sample_range <= '0;
    sample_ch.last_sample  <= 1'b0;
    sample_ch.empty_scan   <= 1'b0;
    pacing      = 1'b0;
    burst_left  = 0;
    gap_max     = 1;
    items_sent  = 0;
    hold_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_sample(directed[i].sample_range, directed[i].last_sample, directed[i].empty_scan);

    phase = 0;
    while (phase < RANDOM_PHASES) begin
      case (phase)
        0: begin
          reg_plan[REG_RANGE_FLOOR]      = '0;
          reg_plan[REG_RANGE_CEILING]    = '1;
          reg_plan[REG_WALL_THRESHOLD]   = '1;
          reg_plan[REG_FRONT_INDEX]      = '0;
          reg_plan[REG_RIGHT_INDEX]      = '1;
          reg_plan[REG_LEFT_INDEX]       = 16'd2047;
          reg_plan[REG_RIGHT_DIAG_INDEX] = 16'd1;
          reg_plan[REG_LEFT_DIAG_INDEX]  = 16'd2;
        end
        1: begin
          reg_plan[REG_RANGE_FLOOR]    = '1;
          reg_plan[REG_RANGE_CEILING]  = '0;
          reg_plan[REG_WALL_THRESHOLD] = '0;
          for (int d = 0; d < NUM_DIRS; d++) reg_plan[REG_FRONT_INDEX + d] = $urandom;
        end
        default: begin
          reg_plan[REG_RANGE_FLOOR]    = $urandom_range(0, 400);
          reg_plan[REG_RANGE_CEILING]  = $urandom_range(800, 4000);
          reg_plan[REG_WALL_THRESHOLD] = $urandom_range(reg_plan[REG_RANGE_CEILING],
                                                        reg_plan[REG_RANGE_FLOOR]);
          for (int d = 0; d < NUM_DIRS; d++)
            reg_plan[REG_FRONT_INDEX + d] = {5'($urandom), 11'($urandom_range(0, 24))};
        end
      endcase
      configure();
      pacing     = (phase % 3 != 1);
      gap_max    = (phase % 2 != 0) ? 3 : 12;
      short_only = (phase == 3);
      if (short_only) begin
        pacing      = 1'b0;
        hold_cycles = 700;
      end
      phase_end = items_sent + $urandom_range(100, 180);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 19) == 0)
          send_sample(RANGE_W'($urandom), 1'($urandom), 1'b1);
        else
          send_scan(pick_len(short_only), 1'b1);
      end
      phase++;
    end

    reg_plan[REG_RANGE_FLOOR]    = RST_RANGE_FLOOR;
    reg_plan[REG_RANGE_CEILING]  = RST_RANGE_CEILING;
    reg_plan[REG_WALL_THRESHOLD] = RST_WALL_THRESHOLD;
    for (int d = 0; d < NUM_DIRS; d++) reg_plan[REG_FRONT_INDEX + d] = RST_DIR_INDEX[d];
    configure();
    pacing  = 1'b1;
    gap_max = 4;
    for (int i = 0; i < 2; i++) begin
      send_scan($urandom_range(280, 380), 1'b0);
      send_scan(pick_len(1'b0), 1'b1);
    end

    drain();
    if (tracker.errors == 0 && tracker.due_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lsse_pkg.sv
hw/rtl/lsse_if.sv
hw/rtl/lsse_front.sv
hw/rtl/lsse_fifo.sv
hw/rtl/lsse_back.sv
hw/rtl/lidar_scan_sector_extractor_core.sv
test/lidar_scan_sector_extractor_core_test.sv
